// ===== rtl/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;
	localparam int SLOTS_DEF = 1024;
	localparam int VALUE_BITS_DEF = 64;
	localparam logic [43:0] HASH_MASK = 44'hFFFFFFFFFFF;
	localparam logic [16:0] LCG_MUL = 17'd69069;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_TRY    = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_ERASE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EXISTS  = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_FULL  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] key;
		logic [63:0] value_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  slot_index;
		logic [63:0] value_out;
		logic [10:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic [43:0] seed;
	} hash_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/open_address_hash_table.sv =====
`default_nettype none
// Channel  | ports                         | handshake
// request  | start, busy, req (req_t)      | taken when start & !busy
// result   | rsp_valid, rsp (rsp_t)        | one cycle strobe, no stall
// An item passes through setup (accept, then the seed states) and then, per probed
// slot, through the hash step, the memory read and the evaluation. The result strobe
// is registered from S_DONE, and busy is already low while the strobe is high,
// so a new item can be taken while the result is shown.
// After reset a clearing pass empties the mark memory;
// busy is high during it. The receiver cannot stall results.
module open_address_hash_table
	import oaht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      rsp_valid,
	output rsp_t      rsp
);
	localparam int AW = $clog2(SLOTS);
	localparam int KVW = 64 + VALUE_BITS;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SEED  = 7'b0000100,
		S_HASH  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_EVAL  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0]            mark_mem [SLOTS];
	logic [KVW-1:0]        kv_mem   [SLOTS];
	logic [1:0]            mark_rd_q;
	logic [KVW-1:0]        kv_rd_q;
	logic [63:0]           key_rd;
	logic [VALUE_BITS-1:0] val_rd;

	req_t        req_q;
	logic [63:0] seed_s1;
	logic [AW:0] count_q;
	logic [AW:0] probes_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] tomb_q;
	logic          have_tomb_q;
	logic [AW:0]   live_q;
	logic [AW-1:0] clr_q;
	status_t       st_q;
	logic [9:0]    slot_q;
	logic [63:0]   vout_q;

	hash_ctl_t hctl;
	logic [43:0] hash;
	logic        hdone;

	oaht_hash u_hash (.clk(clk), .arst_n(arst_n), .ctl(hctl), .hash(hash), .done(hdone));

	// Each evaluation restarts the hash unit from the slot just probed, so the
	// next probe gets exactly one step of the sequence.
	assign hctl = {(state_q == S_SEED) || (state_q == S_EVAL),
		(state_q == S_SEED) ? (seed_s1[43:0] & HASH_MASK) : hash};

	logic        we;
	logic [AW-1:0] waddr;
	logic [1:0]  wmark;
	logic        wkv;

	// Memories: one read and one write port each.
	always_ff @(posedge clk) begin
		if (we) begin
			mark_mem[waddr] <= wmark;
		end
		if (wkv) begin
			kv_mem[waddr] <= {req_q.key, req_q.value_in[VALUE_BITS-1:0]};
		end
		mark_rd_q <= mark_mem[addr_q];
		kv_rd_q   <= kv_mem[addr_q];
	end

	assign key_rd = kv_rd_q[KVW-1:VALUE_BITS];
	assign val_rd = kv_rd_q[VALUE_BITS-1:0];

	// The key * 69069 + 1 seed: 64 x 17 split as low and high halves.
	logic [48:0] slo_s1;
	logic [48:0] shi_s1;
	always_ff @(posedge clk) begin
		slo_s1 <= {17'd0, req_q.key[31:0]} * 49'(LCG_MUL);
		shi_s1 <= {17'd0, req_q.key[63:32]} * 49'(LCG_MUL);
		seed_s1 <= 64'(slo_s1) + {shi_s1[31:0], 32'd0} + 64'd1;
	end

	logic is_ins;
	logic hit;
	assign is_ins = (req_q.mode == MODE_INSERT) || (req_q.mode == MODE_TRY);
	assign hit = (mark_rd_q == MARK_FULL) && (key_rd == req_q.key);

	always_comb begin
		we    = 1'b0;
		wkv   = 1'b0;
		waddr = addr_q;
		wmark = MARK_FULL;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wmark = MARK_EMPTY;
		end else if (state_q == S_EVAL && !hit) begin
			if (is_ins && (mark_rd_q == MARK_EMPTY
					|| (probes_q == AW'(0) + (AW+1)'(SLOTS) - 1'b1 && have_tomb_q)
					|| (!have_tomb_q && mark_rd_q == MARK_TOMB
						&& probes_q == (AW+1)'(SLOTS) - 1'b1))) begin
				we  = 1'b1;
				wkv = 1'b1;
				waddr = (have_tomb_q || mark_rd_q == MARK_TOMB) && mark_rd_q != MARK_EMPTY
					? (have_tomb_q ? tomb_q : addr_q)
					: (have_tomb_q ? tomb_q : addr_q);
			end
		end else if (state_q == S_EVAL && hit && req_q.mode == MODE_ERASE) begin
			we    = 1'b1;
			wmark = MARK_TOMB;
		end
	end

	logic last_probe;
	assign last_probe = (probes_q == (AW+1)'(SLOTS) - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			live_q      <= '0;
			rsp_valid   <= 1'b0;
			probes_q    <= '0;
			have_tomb_q <= 1'b0;
			req_q       <= '0;
			count_q     <= '0;
			addr_q      <= '0;
			tomb_q      <= '0;
			st_q        <= ST_OK;
			slot_q      <= '0;
			vout_q      <= '0;
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q       <= req;
						probes_q    <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= S_SEED;
						count_q     <= '0;
					end
				end
				S_SEED: begin
					count_q <= count_q + 1'b1;
					if (count_q == (AW+1)'(2)) begin
						state_q <= S_HASH;
						count_q <= '0;
					end else begin
						state_q <= S_SEED;
					end
				end
				S_HASH: begin
					if (hdone || count_q == (AW+1)'(1)) begin
						addr_q  <= hash[AW-1:0];
						state_q <= S_READ;
					end
					count_q <= count_q + 1'b1;
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					vout_q <= '0;
					slot_q <= '0;
					st_q   <= ST_OK;
					if (hit) begin
						slot_q <= 10'(addr_q);
						if (req_q.mode == MODE_INSERT) st_q <= ST_EXISTS;
						if (req_q.mode == MODE_FIND) vout_q <= 64'(val_rd);
						if (req_q.mode == MODE_ERASE && live_q != '0) live_q <= live_q - 1'b1;
						state_q <= S_DONE;
					end else if (mark_rd_q == MARK_EMPTY || last_probe) begin
						if (is_ins && (mark_rd_q == MARK_EMPTY || have_tomb_q
								|| mark_rd_q == MARK_TOMB)) begin
							slot_q <= 10'(waddr);
							live_q <= live_q + 1'b1;
						end else if (is_ins) begin
							st_q <= ST_FULL;
						end else begin
							st_q <= ST_MISSING;
						end
						state_q <= S_DONE;
					end else begin
						if (mark_rd_q == MARK_TOMB && !have_tomb_q) begin
							have_tomb_q <= 1'b1;
							tomb_q      <= addr_q;
						end
						probes_q <= probes_q + 1'b1;
						count_q  <= '0;
						state_q  <= S_HASH;
					end
				end
				S_DONE: begin
					rsp_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = {st_q, slot_q, vout_q, 11'(live_q)};
	assign busy = (state_q != S_IDLE);

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= (AW+1)'(SLOTS)) else $error("live count overflow");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid) else $error("double result");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
endmodule
`default_nettype wire

// ===== rtl/oaht_hash.sv =====
`default_nettype none
// Probe hash unit: h' = (h * 69069 + 1) mod 2^44; each step registers the partial products, then updates h.
// The 44 x 17 product is split into a low and high partial product.
module oaht_hash
	import oaht_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hash_ctl_t   ctl,
	output logic [43:0]      hash,
	output logic             done
);
	logic [43:0] h_q;
	logic [38:0] lo_s1;
	logic [43:0] hi_s1;
	logic        phase_q;
	logic        busy_q;

	always_ff @(posedge clk) begin
		lo_s1 <= {5'd0, h_q[21:0]} * 39'(LCG_MUL);
		hi_s1 <= 44'(h_q[43:22] * 39'(LCG_MUL));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			busy_q  <= 1'b0;
			h_q     <= '0;
		end else if (ctl.start) begin
			h_q     <= ctl.seed;
			phase_q <= 1'b0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				h_q <= (44'(lo_s1) + {hi_s1[21:0], 22'd0} + 44'd1) & HASH_MASK;
			end
		end
	end

	assign hash = h_q;
	assign done = busy_q & phase_q;
endmodule
`default_nettype wire

// ===== sim/open_address_hash_table_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module open_address_hash_table_tb;
	import oaht_pkg::*;

	localparam int NSLOT = 1024;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	open_address_hash_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	req_t pending_ops[$];
	rsp_t expected_rsps[$];
	int gap_pct = 0;
	bit hold_sender = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;

	// Shadow copy of the table contents.
	mark_t tbl_mark[NSLOT];
	logic [63:0] tbl_key[NSLOT];
	logic [63:0] tbl_value[NSLOT];
	logic [10:0] tbl_live;

	function automatic logic [63:0] next_probe(logic [63:0] h);
		return (h * 64'd69069 + 64'd1) & 64'h00000FFFFFFFFFFF;
	endfunction

	// Runs one operation on the shadow table and returns the result it should give.
	function automatic rsp_t apply_op(req_t op);
		rsp_t r;
		logic [63:0] h;
		int s;
		int tomb;
		int hit;
		bit have_tomb;
		bit have_empty;
		bit dup;
		r = '0;
		h = next_probe(op.key);
		tomb = 0;
		hit = 0;
		have_tomb = 0;
		have_empty = 0;
		dup = 0;
		for (int n = 0; n < NSLOT; n++) begin
			s = int'(h[9:0]);
			if (tbl_mark[s] == MARK_EMPTY) begin
				have_empty = 1;
				break;
			end
			if (tbl_mark[s] == MARK_FULL && tbl_key[s] == op.key) begin
				dup = 1;
				hit = s;
				break;
			end
			if (tbl_mark[s] == MARK_TOMB && !have_tomb) begin
				have_tomb = 1;
				tomb = s;
			end
			h = next_probe(h);
		end
		if (have_empty)
			hit = s;
		r.status = ST_OK;
		if (op.mode == MODE_INSERT || op.mode == MODE_TRY) begin
			if (dup) begin
				r.status = (op.mode == MODE_INSERT) ? ST_EXISTS : ST_OK;
				r.slot_index = hit[9:0];
			end else if (have_tomb || have_empty) begin
				s = have_tomb ? tomb : hit;
				tbl_mark[s] = MARK_FULL;
				tbl_key[s] = op.key;
				tbl_value[s] = op.value_in;
				tbl_live = tbl_live + 11'd1;
				r.slot_index = s[9:0];
			end else begin
				r.status = ST_FULL;
			end
		end else if (dup) begin
			r.slot_index = hit[9:0];
			if (op.mode == MODE_FIND) begin
				r.value_out = tbl_value[hit];
			end else begin
				tbl_mark[hit] = MARK_TOMB;
				if (tbl_live > 11'd0)
					tbl_live = tbl_live - 11'd1;
			end
		end else begin
			r.status = ST_MISSING;
		end
		r.entry_count = tbl_live;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else if (start && busy) begin
			start <= 1'b1;
		end else if (pending_ops.size() > 0 && !hold_sender &&
				$urandom_range(0, 99) >= gap_pct) begin
			if (start)
				expected_rsps.push_back(apply_op(req));
			start <= 1'b1;
			req <= pending_ops.pop_front();
		end else begin
			if (start)
				expected_rsps.push_back(apply_op(req));
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || rsp_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
			if (rsp_valid) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d slot %0d", rsp.status,
							rsp.slot_index);
				end else begin
					rsp_t want;
					want = expected_rsps.pop_front();
					if (rsp !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display(
								"mismatch: exp st %0d slot %0d val %h cnt %0d, got st %0d slot %0d val %h cnt %0d",
								want.status, want.slot_index, want.value_out, want.entry_count,
								rsp.status, rsp.slot_index, rsp.value_out, rsp.entry_count);
					end
				end
			end
		end
	end

	task automatic add_op(mode_t m, logic [63:0] k, logic [63:0] v);
		req_t op;
		op.mode = m;
		op.key = k;
		op.value_in = v;
		pending_ops.push_back(op);
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	logic [63:0] key_pool[48];
	logic [63:0] fresh_base;

	task automatic add_random(int count);
		mode_t m;
		logic [63:0] k;
		for (int i = 0; i < count; i++) begin
			m = mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, 47)];
			else
				k = {$urandom, $urandom};
			add_op(m, k, {$urandom, $urandom});
		end
	endtask

	initial begin
		int phase_gaps[4];
		for (int i = 0; i < NSLOT; i++) begin
			tbl_mark[i] = MARK_EMPTY;
			tbl_key[i] = '0;
			tbl_value[i] = '0;
		end
		tbl_live = '0;
		for (int i = 0; i < 48; i++)
			key_pool[i] = {$urandom, $urandom};
		fresh_base = {$urandom, 32'h0};
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Duplicates, misses, tombstone reuse and the key extremes.
		add_op(MODE_INSERT, 64'd0, 64'hFFFFFFFFFFFFFFFF);
		add_op(MODE_INSERT, 64'd0, 64'd1);
		add_op(MODE_TRY, 64'd0, 64'd2);
		add_op(MODE_FIND, 64'd0, 64'd0);
		add_op(MODE_FIND, '1, 64'd0);
		add_op(MODE_ERASE, '1, 64'd0);
		add_op(MODE_INSERT, '1, '1);
		add_op(MODE_FIND, '1, 64'd0);
		add_op(MODE_ERASE, 64'd0, 64'd0);
		add_op(MODE_FIND, 64'd0, 64'd0);
		add_op(MODE_ERASE, 64'd0, 64'd0);
		add_op(MODE_TRY, 64'd5, 64'h5555555555555555);
		add_op(MODE_INSERT, 64'd0, 64'hAAAAAAAAAAAAAAAA);
		add_op(MODE_FIND, 64'd5, 64'd0);
		add_op(MODE_ERASE, 64'd5, 64'd0);
		add_op(MODE_TRY, 64'd5, 64'd0);
		add_op(MODE_FIND, 64'd5, 64'd0);
		add_op(MODE_ERASE, '1, 64'd0);
		add_op(MODE_ERASE, 64'd0, 64'd0);
		add_op(MODE_ERASE, 64'd5, 64'd0);
		drain();

		phase_gaps = '{0, 83, 34, 0};
		for (int p = 0; p < 4; p++) begin
			gap_pct = phase_gaps[p];
			add_random(130);
			while (pending_ops.size() > 65)
				@(posedge clk);
			// The sender holds off halfway until the block has answered everything.
			hold_sender = 1'b1;
			while (start || expected_rsps.size() > 0)
				@(posedge clk);
			hold_sender = 1'b0;
			drain();
		end

		// Fill the table with fresh keys until inserts report it full.
		gap_pct = 0;
		for (int i = 0; i < 1060; i++)
			add_op(MODE_INSERT, fresh_base + i, {$urandom, $urandom});
		for (int i = 0; i < 4; i++)
			add_op(MODE_FIND, fresh_base + 2000 + i, 64'd0);
		add_op(MODE_TRY, fresh_base + 3000, 64'd0);
		for (int i = 0; i < 30; i++) begin
			add_op(MODE_ERASE, fresh_base + $urandom_range(0, 1059), 64'd0);
			add_op(MODE_FIND, fresh_base + $urandom_range(0, 1059), 64'd0);
		end
		for (int i = 0; i < 20; i++)
			add_op(mode_t'($urandom_range(0, 1)), fresh_base + $urandom_range(0, 1200),
				{$urandom, $urandom});
		drain();

		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== open_address_hash_table.f =====
rtl/oaht_pkg.sv
rtl/oaht_hash.sv
rtl/open_address_hash_table.sv
sim/open_address_hash_table_tb.sv
